// ===== sv/brs_pkg.sv =====
// Package for the batched running statistics block: sizes, state codes, helpers.
package brs_pkg;

    localparam int CHANNELS   = 7;
    localparam int BATCH_SIZE = 10;

    localparam int CH_W     = 3;
    localparam int SAMPLE_W = 26;
    localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int FILL_W   = $clog2(BATCH_SIZE + 1);
    localparam int RAM_DEPTH = CHANNELS * BATCH_SIZE;
    localparam int ADDR_W   = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1;

    localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;
    localparam logic signed [SAMPLE_W-1:0] S26_MAX = 26'sh1FF_FFFF;
    localparam logic signed [SAMPLE_W-1:0] S26_MIN = 26'sh200_0000;

    localparam int DIV_STEPS  = 64;
    localparam int SQRT_STEPS = 32;

    typedef enum logic [3:0] {
        S_IDLE,
        S_UPD,
        S_PREP,
        S_DIVM,
        S_MFIX,
        S_RD,
        S_MUL,
        S_ACC,
        S_WB,
        S_DIVV,
        S_SQI,
        S_SQRT,
        S_EMIT
    } t_state;

endpackage

// ===== sv/brs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module brs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== sv/batched_running_statistics_core.sv =====
// Top level of the batched running statistics block for several sensor channels.
// Each accepted beat carries one signed Q17.8 sample for one channel. The block keeps,
// per channel, a saturating sample count, a 64-bit running sum, the max and min seen
// and a saturating accumulator of squared deviations, and buffers the channel's current
// batch in a RAM. A beat that does not end a batch only passes through accept and update.
// A beat that ends a batch (batch_end set, or the buffer just filled) runs a small
// sequencer around shared units: a one-bit-per-cycle restoring divider gives the
// rounded mean, the buffer is walked through a 27x27 multiplier and a saturating
// adder (read, multiply, accumulate per buffered sample), the same divider gives
// acc/count and a one-bit-per-cycle square root gives the std, and the result is
// emitted once the output register is free. The input is stalled while an item is
// being worked on and during reset; a finished result sits in an output register,
// so the next beat is taken while it waits. Items whose channel is out of range are
// dropped silently.
module batched_running_statistics_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [brs_pkg::CH_W-1:0]         i_channel,
    input  logic signed [brs_pkg::SAMPLE_W-1:0] i_sample_value,
    input  logic                             i_batch_end,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [brs_pkg::CH_W-1:0]         o_out_channel,
    output logic signed [brs_pkg::SAMPLE_W-1:0] o_mean_value,
    output logic signed [brs_pkg::SAMPLE_W-1:0] o_max_value,
    output logic signed [brs_pkg::SAMPLE_W-1:0] o_min_value,
    output logic [brs_pkg::SAMPLE_W-1:0]     o_std_value
);
    import brs_pkg::*;

    t_state r_state, n_state;

    // Per-channel statistics
    logic [31:0]                r_cnt  [CHANNELS];
    logic signed [63:0]         r_sum  [CHANNELS];
    logic signed [SAMPLE_W-1:0] r_max  [CHANNELS];
    logic signed [SAMPLE_W-1:0] r_min  [CHANNELS];
    logic [63:0]                r_sqd  [CHANNELS];
    logic [FILL_W-1:0]          r_fill [CHANNELS];

    // Latched beat
    logic [CH_W-1:0]            r_ch;
    logic signed [SAMPLE_W-1:0] r_x;
    logic                       r_end;
    logic [CH_IDX_W-1:0]        ch;

    // Shared divider
    logic [63:0] r_dq;
    logic [31:0] r_rem;
    logic [31:0] r_dvsr;
    logic [32:0] div_sh;
    logic        div_ge;
    logic [5:0]  r_step;

    // Mean and buffer walk
    logic                       r_neg;
    logic signed [SAMPLE_W-1:0] r_mean;
    logic [FILL_W-1:0]          r_idx;
    logic [63:0]                r_acc;
    logic [53:0]                r_sq;
    logic signed [SAMPLE_W:0]   diff;
    logic [SAMPLE_W:0]          adiff;
    logic [64:0]                acc_sum;
    logic [SAMPLE_W:0]          mneg;

    // Square root
    logic [63:0] r_v;
    logic [63:0] r_root;
    logic [63:0] r_bit;
    logic [63:0] sq_try;

    // Buffer RAM
    logic                       ram_we;
    logic [ADDR_W-1:0]          ram_waddr;
    logic [ADDR_W-1:0]          ram_raddr;
    logic [SAMPLE_W-1:0]        ram_rdata;
    logic [ADDR_W-1:0]          base;

    logic in_acc;
    logic out_free;
    logic ch_ok;
    logic ends;
    logic signed [63:0] cur_sum;

    assign ch       = r_ch[CH_IDX_W-1:0];
    assign ch_ok    = ({1'b0, r_ch} < (CH_W+1)'(CHANNELS));
    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !o_out_valid || !i_out_stall;
    assign base     = ADDR_W'(ch) * ADDR_W'(BATCH_SIZE);
    // The batch ends on the flag or when this sample fills the buffer
    assign ends     = r_end || (r_fill[ch] >= FILL_W'(BATCH_SIZE - 1));

    assign div_sh   = {r_rem, r_dq[63]};
    assign div_ge   = (div_sh >= {1'b0, r_dvsr});

    assign diff     = {ram_rdata[SAMPLE_W-1], ram_rdata} - {r_mean[SAMPLE_W-1], r_mean};
    assign adiff    = diff[SAMPLE_W] ? -diff : diff;
    assign acc_sum  = {1'b0, r_acc} + {11'b0, r_sq};
    assign sq_try   = r_root + r_bit;
    assign mneg     = -r_dq[SAMPLE_W:0];
    assign cur_sum  = r_sum[ch];

    brs_ram #(
        .WIDTH(SAMPLE_W),
        .DEPTH(RAM_DEPTH)
    ) u_buf (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(r_x),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (in_acc) n_state = S_UPD;
            S_UPD: begin
                if (!ch_ok || !ends) n_state = S_IDLE;
                else                 n_state = S_PREP;
            end
            S_PREP: n_state = S_DIVM;
            S_DIVM: if (r_step == 6'(DIV_STEPS - 1)) n_state = S_MFIX;
            S_MFIX: n_state = S_RD;
            S_RD:   n_state = S_MUL;
            S_MUL:  n_state = S_ACC;
            S_ACC: begin
                if (r_idx + 1'b1 >= r_fill[ch]) n_state = S_WB;
                else                            n_state = S_RD;
            end
            S_WB:   n_state = S_DIVV;
            S_DIVV: if (r_step == 6'(DIV_STEPS - 1)) n_state = S_SQI;
            S_SQI:  n_state = S_SQRT;
            S_SQRT: if (r_step == 6'(SQRT_STEPS - 1)) n_state = S_EMIT;
            S_EMIT: if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs of the sequencer
    always_comb begin
        o_in_stall = 1'b1;
        ram_we     = 1'b0;
        ram_waddr  = base + ADDR_W'(r_fill[ch]);
        ram_raddr  = base + ADDR_W'(r_idx);
        unique case (r_state)
            // Hold the input off while reset is applied
            S_IDLE:  o_in_stall = !i_rst_n;
            S_UPD:   ram_we = ch_ok && (r_fill[ch] < FILL_W'(BATCH_SIZE));
            default: ;
        endcase
    end

    // Control state and statistics
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            o_out_valid <= 1'b0;
            for (int k = 0; k < CHANNELS; k++) begin
                r_cnt[k]  <= '0;
                r_sum[k]  <= '0;
                r_max[k]  <= S26_MIN;
                r_min[k]  <= S26_MAX;
                r_sqd[k]  <= '0;
                r_fill[k] <= '0;
            end
        end else begin
            r_state <= n_state;
            // Raise on emit, drop once the waiting result is taken
            if (r_state == S_EMIT && out_free) o_out_valid <= 1'b1;
            else if (!i_out_stall)             o_out_valid <= 1'b0;
            unique case (r_state)
                S_UPD: begin
                    if (ch_ok) begin
                        if (r_fill[ch] < FILL_W'(BATCH_SIZE)) r_fill[ch] <= r_fill[ch] + 1'b1;
                        if (r_x > r_max[ch]) r_max[ch] <= r_x;
                        if (r_x < r_min[ch]) r_min[ch] <= r_x;
                        if (r_cnt[ch] != COUNT_MAX) begin
                            r_cnt[ch] <= r_cnt[ch] + 1'b1;
                            r_sum[ch] <= r_sum[ch] + 64'(r_x);
                        end
                    end
                end
                S_WB: begin
                    r_sqd[ch]  <= r_acc;
                    r_fill[ch] <= '0;
                end
                default: ;
            endcase
        end
    end

    // Datapath: latched beat, shared divider, buffer walk, square root, result
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_ch  <= i_channel;
            r_x   <= i_sample_value;
            r_end <= i_batch_end;
        end
        unique case (r_state)
            S_PREP: begin
                r_neg  <= cur_sum[63];
                r_dq   <= (cur_sum[63] ? -cur_sum : cur_sum) + 64'(r_cnt[ch] >> 1);
                r_rem  <= '0;
                r_dvsr <= r_cnt[ch];
                r_step <= '0;
            end
            S_DIVM, S_DIVV: begin
                r_rem  <= div_ge ? 32'(div_sh - {1'b0, r_dvsr}) : div_sh[31:0];
                r_dq   <= {r_dq[62:0], div_ge};
                r_step <= r_step + 1'b1;
            end
            S_MFIX: begin
                // Clamp the quotient, then apply the sign and fit to Q17.8
                if (r_neg) begin
                    if (r_dq >= 64'(33554432)) r_mean <= S26_MIN;
                    else                       r_mean <= mneg[SAMPLE_W-1:0];
                end else begin
                    if (r_dq >= 64'(33554431)) r_mean <= S26_MAX;
                    else                       r_mean <= r_dq[SAMPLE_W-1:0];
                end
                r_acc <= r_sqd[ch];
                r_idx <= '0;
            end
            S_MUL: r_sq <= adiff * adiff;
            S_ACC: begin
                r_acc <= acc_sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : acc_sum[63:0];
                r_idx <= r_idx + 1'b1;
            end
            S_WB: begin
                r_dq   <= r_acc;
                r_rem  <= '0;
                r_dvsr <= r_cnt[ch];
                r_step <= '0;
            end
            S_SQI: begin
                r_v    <= r_dq;
                r_root <= '0;
                r_bit  <= 64'h4000_0000_0000_0000;
                r_step <= '0;
            end
            S_SQRT: begin
                if (r_v >= sq_try) begin
                    r_v    <= r_v - sq_try;
                    r_root <= (r_root >> 1) + r_bit;
                end else begin
                    r_root <= r_root >> 1;
                end
                r_bit  <= r_bit >> 2;
                r_step <= r_step + 1'b1;
            end
            S_EMIT: begin
                if (out_free) begin
                    o_out_channel <= r_ch;
                    o_mean_value  <= r_mean;
                    o_max_value   <= r_max[ch];
                    o_min_value   <= r_min[ch];
                    o_std_value   <= (|r_root[63:SAMPLE_W]) ? '1 : r_root[SAMPLE_W-1:0];
                end
            end
            default: ;
        endcase
    end

    // Hold the input off for at least the cycle after a beat is taken
    a_stall_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_in_stall)
        else $error("input taken while an item is in work");

    // A result appears only from the emit step
    a_emit_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_EMIT))
        else $error("result raised outside emit");

    // The buffer walk stays inside the filled part of the batch
    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ACC) |-> (r_idx < r_fill[ch]))
        else $error("buffer walk past fill");

    // The divider steps through exactly its count before the mean is fixed
    a_div_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MFIX) |-> $past(r_state == S_DIVM) && (r_step == 6'(DIV_STEPS)))
        else $error("divider cut short");

endmodule
